// ===== src/mxt_pkg.sv =====
// shared types and constants for the march x ram test controller
package mxt_pkg;

   localparam int ADDR_WIDTH = 16;
   localparam int NUM_SLOTS  = 8;
   localparam int SLOT_WIDTH = 3;
   localparam int DATA_WIDTH = 32;
   localparam int ALG_WIDTH  = 3;

   typedef enum logic [1:0] {
      RES_NOT_TESTED = 2'd0,
      RES_OK         = 2'd1,
      RES_NOT_OK     = 2'd2,
      RES_UNDEF      = 2'd3
   } result_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_W0_UP     = 3'd1,
      PH_R0W1_UP   = 3'd2,
      PH_R1W0_DOWN = 3'd3,
      PH_R0_DOWN   = 3'd4
   } phase_type;

   typedef enum logic [0:0] {
      CMD_TICK  = 1'b0,
      CMD_START = 1'b1
   } command_type;

   localparam logic [ALG_WIDTH-1:0] ALG_MARCH_X = '0;

   typedef struct packed {
      logic                  access_valid;
      logic                  access_write;
      logic [ADDR_WIDTH-1:0] access_addr;
      logic                  write_word;
      logic                  busy;
      logic                  block_done;
      result_type            block_result;
      result_type            overall_result;
   } step_type;

   typedef struct packed {
      logic                  clear_all;
      logic                  write_en;
      logic [SLOT_WIDTH-1:0] write_slot;
      result_type            write_res;
   } slot_cmd_type;

endpackage

// ===== src/mxt_slot_store.sv =====
// per-slot result memory with valid bits and same-step forwarding
module mxt_slot_store (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  mxt_pkg::slot_cmd_type                cmd,
   input  logic [mxt_pkg::SLOT_WIDTH-1:0]       query_slot,
   output mxt_pkg::result_type                  queried
);

   logic [1:0]                       mem_ff [mxt_pkg::NUM_SLOTS];
   logic [1:0]                       rd_ff;
   logic [mxt_pkg::NUM_SLOTS-1:0]    valid_ff;
   logic [mxt_pkg::NUM_SLOTS-1:0]    valid_in;
   logic                             q_valid_ff;
   logic                             q_hit_ff;
   logic                             q_range_ff;
   logic [1:0]                       q_wdata_ff;
   logic                             wr_ok;
   logic                             rd_ok;

   assign wr_ok = cmd.write_en && (int'(cmd.write_slot) < mxt_pkg::NUM_SLOTS);
   assign rd_ok = int'(query_slot) < mxt_pkg::NUM_SLOTS;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end
      if (wr_ok) begin
         valid_in[cmd.write_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && wr_ok) begin
         mem_ff[cmd.write_slot] <= cmd.write_res;
      end
      if (advance && rd_ok) begin
         rd_ff <= mem_ff[query_slot];
      end
      if (advance) begin
         q_range_ff <= rd_ok;
         q_valid_ff <= rd_ok && valid_in[query_slot];
         q_hit_ff   <= wr_ok && (cmd.write_slot == query_slot);
         q_wdata_ff <= cmd.write_res;
      end
   end

   always_comb begin
      if (!q_range_ff) begin
         queried = mxt_pkg::RES_UNDEF;
      end else if (q_hit_ff) begin
         queried = mxt_pkg::result_type'(q_wdata_ff);
      end else if (q_valid_ff) begin
         queried = mxt_pkg::result_type'(rd_ff);
      end else begin
         queried = mxt_pkg::RES_NOT_TESTED;
      end
   end

endmodule

// ===== src/mxt_engine.sv =====
// march x sequencer: phase, cursor, range and overall result registers
module mxt_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mxt_pkg::ALG_WIDTH-1:0]        csr_write_data,
   input  logic                                 advance,
   input  logic                                 command,
   input  logic [mxt_pkg::ADDR_WIDTH-1:0]       first_addr,
   input  logic [mxt_pkg::ADDR_WIDTH-1:0]       limit_addr,
   input  logic [mxt_pkg::SLOT_WIDTH-1:0]       slot,
   input  logic                                 first_block,
   input  logic                                 last_block,
   input  logic [mxt_pkg::DATA_WIDTH-1:0]       read_data,
   output mxt_pkg::step_type                    step,
   output mxt_pkg::slot_cmd_type                slot_cmd
);

   localparam int AW = mxt_pkg::ADDR_WIDTH;

   logic [mxt_pkg::ALG_WIDTH-1:0]  alg_ff;
   mxt_pkg::phase_type             phase_ff, phase_in;
   logic [AW-1:0]                  cursor_ff, cursor_in;
   logic                           pend_ff, pend_in;
   logic [AW-1:0]                  low_ff, low_in;
   logic [AW-1:0]                  high_ff, high_in;
   logic [mxt_pkg::SLOT_WIDTH-1:0] slot_ff, slot_in;
   logic                           final_ff, final_in;
   mxt_pkg::result_type            overall_ff, overall_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         alg_ff <= mxt_pkg::ALG_MARCH_X;
      end else if (csr_write_enable) begin
         alg_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= mxt_pkg::PH_IDLE;
         cursor_ff  <= '0;
         pend_ff    <= 1'b0;
         low_ff     <= '0;
         high_ff    <= '0;
         slot_ff    <= '0;
         final_ff   <= 1'b0;
         overall_ff <= mxt_pkg::RES_NOT_TESTED;
      end else if (advance) begin
         phase_ff   <= phase_in;
         cursor_ff  <= cursor_in;
         pend_ff    <= pend_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         slot_ff    <= slot_in;
         final_ff   <= final_in;
         overall_ff <= overall_in;
      end
   end

   always_comb begin
      logic          active;
      logic          expect_bit;
      logic          up_end;
      logic [AW:0]   cur_inc;

      phase_in   = phase_ff;
      cursor_in  = cursor_ff;
      pend_in    = pend_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      slot_in    = slot_ff;
      final_in   = final_ff;
      overall_in = overall_ff;
      active     = 1'b0;
      step       = '0;
      slot_cmd   = '0;

      if (command == mxt_pkg::CMD_START && phase_ff == mxt_pkg::PH_IDLE) begin
         low_in   = first_addr;
         high_in  = limit_addr;
         slot_in  = slot;
         final_in = last_block;
         pend_in  = 1'b0;
         if (first_block) begin
            slot_cmd.clear_all = 1'b1;
            overall_in         = mxt_pkg::RES_UNDEF;
         end
         if (alg_ff != mxt_pkg::ALG_MARCH_X) begin
            step.block_done   = 1'b1;
            step.block_result = mxt_pkg::RES_NOT_OK;
         end else if (first_addr >= limit_addr) begin
            step.block_done   = 1'b1;
            step.block_result = mxt_pkg::RES_OK;
         end else begin
            phase_in  = mxt_pkg::PH_W0_UP;
            cursor_in = first_addr;
            active    = 1'b1;
         end
      end else if (phase_ff != mxt_pkg::PH_IDLE) begin
         active = 1'b1;
      end

      cur_inc    = {1'b0, cursor_in} + (AW+1)'(1);
      up_end     = cur_inc >= {1'b0, high_in};
      expect_bit = (phase_in == mxt_pkg::PH_R1W0_DOWN);

      if (active) begin
         case (phase_in)
            mxt_pkg::PH_W0_UP: begin
               step.access_valid = 1'b1;
               step.access_write = 1'b1;
               step.access_addr  = cursor_in;
               if (up_end) begin
                  phase_in  = mxt_pkg::PH_R0W1_UP;
                  cursor_in = low_in;
               end else begin
                  cursor_in = cur_inc[AW-1:0];
               end
            end
            mxt_pkg::PH_R0W1_UP, mxt_pkg::PH_R1W0_DOWN: begin
               if (!pend_in) begin
                  step.access_valid = 1'b1;
                  step.access_addr  = cursor_in;
                  pend_in           = 1'b1;
               end else if (read_data != mxt_pkg::DATA_WIDTH'(expect_bit)) begin
                  step.block_done   = 1'b1;
                  step.block_result = mxt_pkg::RES_NOT_OK;
               end else begin
                  pend_in           = 1'b0;
                  step.access_valid = 1'b1;
                  step.access_write = 1'b1;
                  step.access_addr  = cursor_in;
                  step.write_word   = ~expect_bit;
                  if (phase_in == mxt_pkg::PH_R0W1_UP) begin
                     if (up_end) begin
                        phase_in  = mxt_pkg::PH_R1W0_DOWN;
                        cursor_in = high_in - AW'(1);
                     end else begin
                        cursor_in = cur_inc[AW-1:0];
                     end
                  end else begin
                     if (cursor_in <= low_in) begin
                        phase_in  = mxt_pkg::PH_R0_DOWN;
                        cursor_in = high_in - AW'(1);
                     end else begin
                        cursor_in = cursor_in - AW'(1);
                     end
                  end
               end
            end
            mxt_pkg::PH_R0_DOWN: begin
               if (!pend_in) begin
                  step.access_valid = 1'b1;
                  step.access_addr  = cursor_in;
                  pend_in           = 1'b1;
               end else if (read_data != '0) begin
                  step.block_done   = 1'b1;
                  step.block_result = mxt_pkg::RES_NOT_OK;
               end else if (cursor_in <= low_in) begin
                  step.block_done   = 1'b1;
                  step.block_result = mxt_pkg::RES_OK;
               end else begin
                  cursor_in         = cursor_in - AW'(1);
                  step.access_valid = 1'b1;
                  step.access_addr  = cursor_in;
               end
            end
            default: begin
               phase_in = mxt_pkg::PH_IDLE;
               pend_in  = 1'b0;
            end
         endcase
      end

      if (step.block_done) begin
         slot_cmd.write_en   = 1'b1;
         slot_cmd.write_slot = slot_in;
         slot_cmd.write_res  = step.block_result;
         if (step.block_result != mxt_pkg::RES_OK) begin
            overall_in = mxt_pkg::RES_NOT_OK;
         end
         if (final_in && overall_in == mxt_pkg::RES_UNDEF) begin
            overall_in = mxt_pkg::RES_OK;
         end
         phase_in  = mxt_pkg::PH_IDLE;
         pend_in   = 1'b0;
         cursor_in = '0;
      end

      step.busy           = (phase_in != mxt_pkg::PH_IDLE);
      step.overall_result = overall_in;
   end

endmodule

// ===== src/march_x_ram_test_controller_core.sv =====
// top level of the march x ram test controller
//
//   channel | direction | handshake              | contents
//   req     | in        | req_valid / req_ready  | command, range, slot, flags, read data, query
//   rsp     | out       | rsp_valid / rsp_ready  | access, status, block, overall and queried results
//   csr     | in        | csr_write_enable       | algorithm select
//
// one word in and one word out per cycle; a word is accepted every cycle while the output
// side drains, and each result is registered in the middle and then the output stage
// the slot store is a registered memory read at the query slot on acceptance,
// with forwarding of a write from the same word and valid bits cleared on a first block
// reset is synchronous and clears control state and the slot valid bits
// a stalled output holds one result while one more word can be taken into the middle stage
module march_x_ram_test_controller_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mxt_pkg::ALG_WIDTH-1:0]        csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [mxt_pkg::ADDR_WIDTH-1:0]       req_first_addr,
   input  logic [mxt_pkg::ADDR_WIDTH-1:0]       req_limit_addr,
   input  logic [mxt_pkg::SLOT_WIDTH-1:0]       req_slot,
   input  logic                                 req_first_block,
   input  logic                                 req_last_block,
   input  logic [mxt_pkg::DATA_WIDTH-1:0]       req_read_data,
   input  logic [mxt_pkg::SLOT_WIDTH-1:0]       req_query_slot,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_access_valid,
   output logic                                 rsp_access_write,
   output logic [mxt_pkg::ADDR_WIDTH-1:0]       rsp_access_addr,
   output logic                                 rsp_write_word,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_block_done,
   output logic [1:0]                           rsp_block_result,
   output logic [1:0]                           rsp_overall_result,
   output logic [1:0]                           rsp_queried_result
);

   mxt_pkg::step_type     step;
   mxt_pkg::slot_cmd_type slot_cmd;
   mxt_pkg::result_type   queried;
   logic                  advance;
   logic                  mid_move;

   logic                  mid_valid_ff, mid_valid_in;
   mxt_pkg::step_type     mid_step_ff;
   logic                  out_valid_ff, out_valid_in;
   mxt_pkg::step_type     out_step_ff;
   mxt_pkg::result_type   out_queried_ff;

   assign mid_move     = mid_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !mid_valid_ff || mid_move;
   assign advance      = req_valid && req_ready;
   assign mid_valid_in = advance || (mid_valid_ff && !mid_move);
   assign out_valid_in = mid_move || (out_valid_ff && !rsp_ready);

   mxt_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .advance          (advance),
      .command          (req_command),
      .first_addr       (req_first_addr),
      .limit_addr       (req_limit_addr),
      .slot             (req_slot),
      .first_block      (req_first_block),
      .last_block       (req_last_block),
      .read_data        (req_read_data),
      .step             (step),
      .slot_cmd         (slot_cmd)
   );

   mxt_slot_store u_slot_store (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cmd        (slot_cmd),
      .query_slot (req_query_slot),
      .queried    (queried)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_step_ff <= step;
      end
      if (mid_move) begin
         out_step_ff    <= mid_step_ff;
         out_queried_ff <= queried;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_access_valid   = out_step_ff.access_valid;
   assign rsp_access_write   = out_step_ff.access_write;
   assign rsp_access_addr    = out_step_ff.access_addr;
   assign rsp_write_word     = out_step_ff.write_word;
   assign rsp_busy_res       = out_step_ff.busy;
   assign rsp_block_done     = out_step_ff.block_done;
   assign rsp_block_result   = out_step_ff.block_result;
   assign rsp_overall_result = out_step_ff.overall_result;
   assign rsp_queried_result = out_queried_ff;

endmodule

// ===== sim/tb.sv =====
// testbench for the march x ram test controller: directed table, then checked random runs
module tb;

   localparam int DIR_ROWS = 24;

   typedef struct packed {
      mxt_pkg::command_type           command;
      logic [mxt_pkg::ADDR_WIDTH-1:0] first_addr;
      logic [mxt_pkg::ADDR_WIDTH-1:0] limit_addr;
      logic [mxt_pkg::SLOT_WIDTH-1:0] slot;
      logic                           first_block;
      logic                           last_block;
      logic [mxt_pkg::DATA_WIDTH-1:0] read_data;
      logic [mxt_pkg::SLOT_WIDTH-1:0] query_slot;
   } march_cmd_type;

   typedef struct packed {
      logic                           access_valid;
      logic                           access_write;
      logic [mxt_pkg::ADDR_WIDTH-1:0] access_addr;
      logic                           write_word;
      logic                           busy;
      logic                           block_done;
      mxt_pkg::result_type            block_result;
      mxt_pkg::result_type            overall_result;
      mxt_pkg::result_type            queried_result;
   } march_out_type;

   logic                           clock;
   logic                           reset            = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [mxt_pkg::ALG_WIDTH-1:0]  csr_write_data   = '0;
   logic                           req_valid        = 1'b0;
   logic                           req_ready;
   logic                           req_command      = 1'b0;
   logic [mxt_pkg::ADDR_WIDTH-1:0] req_first_addr   = '0;
   logic [mxt_pkg::ADDR_WIDTH-1:0] req_limit_addr   = '0;
   logic [mxt_pkg::SLOT_WIDTH-1:0] req_slot         = '0;
   logic                           req_first_block  = 1'b0;
   logic                           req_last_block   = 1'b0;
   logic [mxt_pkg::DATA_WIDTH-1:0] req_read_data    = '0;
   logic [mxt_pkg::SLOT_WIDTH-1:0] req_query_slot   = '0;
   logic                           rsp_valid;
   logic                           rsp_ready        = 1'b0;
   logic                           rsp_access_valid;
   logic                           rsp_access_write;
   logic [mxt_pkg::ADDR_WIDTH-1:0] rsp_access_addr;
   logic                           rsp_write_word;
   logic                           rsp_busy_res;
   logic                           rsp_block_done;
   logic [1:0]                     rsp_block_result;
   logic [1:0]                     rsp_overall_result;
   logic [1:0]                     rsp_queried_result;

   march_x_ram_test_controller_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_first_addr     (req_first_addr),
      .req_limit_addr     (req_limit_addr),
      .req_slot           (req_slot),
      .req_first_block    (req_first_block),
      .req_last_block     (req_last_block),
      .req_read_data      (req_read_data),
      .req_query_slot     (req_query_slot),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_access_valid   (rsp_access_valid),
      .rsp_access_write   (rsp_access_write),
      .rsp_access_addr    (rsp_access_addr),
      .rsp_write_word     (rsp_write_word),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_block_done     (rsp_block_done),
      .rsp_block_result   (rsp_block_result),
      .rsp_overall_result (rsp_overall_result),
      .rsp_queried_result (rsp_queried_result)
   );

   // march x state as the controller should hold it
   logic [mxt_pkg::ALG_WIDTH-1:0]  mx_alg;
   mxt_pkg::phase_type             mx_phase;
   logic [mxt_pkg::ADDR_WIDTH-1:0] mx_cursor;
   logic                           mx_read_pend;
   logic [mxt_pkg::ADDR_WIDTH-1:0] mx_low;
   logic [mxt_pkg::ADDR_WIDTH-1:0] mx_high;
   logic [mxt_pkg::SLOT_WIDTH-1:0] mx_slot;
   logic                           mx_final;
   mxt_pkg::result_type            mx_slots [mxt_pkg::NUM_SLOTS];
   mxt_pkg::result_type            mx_overall;

   march_out_type march_out_q [$];
   march_out_type mon_want;
   int            fail_count  = 0;
   int            words_sent  = 0;
   int            blocks_done = 0;
   int            blocks_bad  = 0;
   int            burst_left  = 0;
   int            stall_left  = 0;
   int            stall_mode  = 0;

   march_cmd_type dir_cmd   [DIR_ROWS];
   bit            dir_typed [DIR_ROWS];
   march_out_type dir_out   [DIR_ROWS];

   function automatic void march_reset();
      mx_alg       = mxt_pkg::ALG_MARCH_X;
      mx_phase     = mxt_pkg::PH_IDLE;
      mx_cursor    = '0;
      mx_read_pend = 1'b0;
      mx_low       = '0;
      mx_high      = '0;
      mx_slot      = '0;
      mx_final     = 1'b0;
      foreach (mx_slots[i]) mx_slots[i] = mxt_pkg::RES_NOT_TESTED;
      mx_overall   = mxt_pkg::RES_NOT_TESTED;
   endfunction

   function automatic void close_block(mxt_pkg::result_type res);
      if (int'(mx_slot) < mxt_pkg::NUM_SLOTS) mx_slots[mx_slot] = res;
      if (res != mxt_pkg::RES_OK) mx_overall = mxt_pkg::RES_NOT_OK;
      if (mx_final && mx_overall == mxt_pkg::RES_UNDEF) mx_overall = mxt_pkg::RES_OK;
      mx_phase     = mxt_pkg::PH_IDLE;
      mx_read_pend = 1'b0;
      mx_cursor    = '0;
   endfunction

   function automatic march_out_type march_step(march_cmd_type c);
      march_out_type o;
      logic          run;
      logic          pat;
      o   = '0;
      run = 1'b0;
      if (c.command == mxt_pkg::CMD_START && mx_phase == mxt_pkg::PH_IDLE) begin
         mx_low       = c.first_addr;
         mx_high      = c.limit_addr;
         mx_slot      = c.slot;
         mx_final     = c.last_block;
         mx_read_pend = 1'b0;
         if (c.first_block) begin
            foreach (mx_slots[i]) mx_slots[i] = mxt_pkg::RES_NOT_TESTED;
            mx_overall = mxt_pkg::RES_UNDEF;
         end
         if (mx_alg != mxt_pkg::ALG_MARCH_X) begin
            o.block_done   = 1'b1;
            o.block_result = mxt_pkg::RES_NOT_OK;
            close_block(mxt_pkg::RES_NOT_OK);
         end else if (c.first_addr >= c.limit_addr) begin
            o.block_done   = 1'b1;
            o.block_result = mxt_pkg::RES_OK;
            close_block(mxt_pkg::RES_OK);
         end else begin
            mx_phase  = mxt_pkg::PH_W0_UP;
            mx_cursor = c.first_addr;
            run       = 1'b1;
         end
      end else if (mx_phase != mxt_pkg::PH_IDLE) begin
         run = 1'b1;
      end

      if (run) begin
         case (mx_phase)
            mxt_pkg::PH_W0_UP: begin
               o.access_valid = 1'b1;
               o.access_write = 1'b1;
               o.access_addr  = mx_cursor;
               if (int'(mx_cursor) + 1 >= int'(mx_high)) begin
                  mx_phase  = mxt_pkg::PH_R0W1_UP;
                  mx_cursor = mx_low;
               end else begin
                  mx_cursor = mx_cursor + 1'b1;
               end
            end
            mxt_pkg::PH_R0W1_UP, mxt_pkg::PH_R1W0_DOWN: begin
               pat = (mx_phase == mxt_pkg::PH_R1W0_DOWN);
               if (!mx_read_pend) begin
                  o.access_valid = 1'b1;
                  o.access_addr  = mx_cursor;
                  mx_read_pend   = 1'b1;
               end else if (c.read_data != {31'd0, pat}) begin
                  o.block_done   = 1'b1;
                  o.block_result = mxt_pkg::RES_NOT_OK;
                  close_block(mxt_pkg::RES_NOT_OK);
               end else begin
                  mx_read_pend   = 1'b0;
                  o.access_valid = 1'b1;
                  o.access_write = 1'b1;
                  o.access_addr  = mx_cursor;
                  o.write_word   = ~pat;
                  if (mx_phase == mxt_pkg::PH_R0W1_UP) begin
                     if (int'(mx_cursor) + 1 >= int'(mx_high)) begin
                        mx_phase  = mxt_pkg::PH_R1W0_DOWN;
                        mx_cursor = mx_high - 1'b1;
                     end else begin
                        mx_cursor = mx_cursor + 1'b1;
                     end
                  end else begin
                     if (mx_cursor <= mx_low) begin
                        mx_phase  = mxt_pkg::PH_R0_DOWN;
                        mx_cursor = mx_high - 1'b1;
                     end else begin
                        mx_cursor = mx_cursor - 1'b1;
                     end
                  end
               end
            end
            mxt_pkg::PH_R0_DOWN: begin
               if (!mx_read_pend) begin
                  o.access_valid = 1'b1;
                  o.access_addr  = mx_cursor;
                  mx_read_pend   = 1'b1;
               end else if (c.read_data != '0) begin
                  o.block_done   = 1'b1;
                  o.block_result = mxt_pkg::RES_NOT_OK;
                  close_block(mxt_pkg::RES_NOT_OK);
               end else if (mx_cursor <= mx_low) begin
                  o.block_done   = 1'b1;
                  o.block_result = mxt_pkg::RES_OK;
                  close_block(mxt_pkg::RES_OK);
               end else begin
                  mx_cursor      = mx_cursor - 1'b1;
                  o.access_valid = 1'b1;
                  o.access_addr  = mx_cursor;
               end
            end
            default: begin
               mx_phase     = mxt_pkg::PH_IDLE;
               mx_read_pend = 1'b0;
            end
         endcase
      end

      o.busy           = (mx_phase != mxt_pkg::PH_IDLE);
      o.overall_result = mx_overall;
      o.queried_result = (int'(c.query_slot) < mxt_pkg::NUM_SLOTS) ? mx_slots[c.query_slot]
                                                                  : mxt_pkg::RES_UNDEF;
      return o;
   endfunction

   function automatic march_cmd_type mk_cmd(mxt_pkg::command_type cmd, logic [15:0] sa,
                                            logic [15:0] ea, logic [2:0] slot, logic first,
                                            logic last, logic [31:0] rdata,
                                            logic [2:0] qslot);
      march_cmd_type c;
      c.command     = cmd;
      c.first_addr  = sa;
      c.limit_addr  = ea;
      c.slot        = slot;
      c.first_block = first;
      c.last_block  = last;
      c.read_data   = rdata;
      c.query_slot  = qslot;
      return c;
   endfunction

   function automatic march_out_type mk_out(logic av, logic aw, logic [15:0] addr, logic ww,
                                            logic busy, logic done,
                                            mxt_pkg::result_type bres,
                                            mxt_pkg::result_type ovr,
                                            mxt_pkg::result_type qres);
      march_out_type o;
      o.access_valid   = av;
      o.access_write   = aw;
      o.access_addr    = addr;
      o.write_word     = ww;
      o.busy           = busy;
      o.block_done     = done;
      o.block_result   = bres;
      o.overall_result = ovr;
      o.queried_result = qres;
      return o;
   endfunction

   // random tick; while a read is pending the data is mostly the right pattern
   function automatic march_cmd_type make_tick();
      march_cmd_type c;
      logic [31:0]   want;
      c.command     = ($urandom_range(0, 19) == 0) ? mxt_pkg::CMD_START : mxt_pkg::CMD_TICK;
      c.first_addr  = 16'($urandom);
      c.limit_addr  = 16'($urandom);
      c.slot        = 3'($urandom);
      c.first_block = 1'($urandom);
      c.last_block  = 1'($urandom);
      c.read_data   = $urandom;
      c.query_slot  = 3'($urandom);
      if (mx_read_pend && mx_phase != mxt_pkg::PH_IDLE && mx_phase != mxt_pkg::PH_W0_UP) begin
         want        = (mx_phase == mxt_pkg::PH_R1W0_DOWN) ? 32'd1 : 32'd0;
         c.read_data = want;
         if ($urandom_range(0, 59) == 0) begin
            case ($urandom_range(0, 2))
               0:       c.read_data = $urandom;
               1:       c.read_data = want ^ (32'd1 << $urandom_range(0, 31));
               default: c.read_data = ~want;
            endcase
         end
      end
      return c;
   endfunction

   task automatic issue_word(input march_cmd_type c, input bit typed,
                             input march_out_type typed_out);
      march_out_type predicted;
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_valid       <= 1'b1;
      req_command     <= c.command;
      req_first_addr  <= c.first_addr;
      req_limit_addr  <= c.limit_addr;
      req_slot        <= c.slot;
      req_first_block <= c.first_block;
      req_last_block  <= c.last_block;
      req_read_data   <= c.read_data;
      req_query_slot  <= c.query_slot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      words_sent++;
      predicted = march_step(c);
      march_out_q.push_back(typed ? typed_out : predicted);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (march_out_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_alg(input logic [mxt_pkg::ALG_WIDTH-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      mx_alg = value;
   endtask

   task automatic run_block();
      march_cmd_type c;
      int unsigned   span;
      int unsigned   pick;
      c         = make_tick();
      c.command = mxt_pkg::CMD_START;
      pick      = $urandom_range(0, 99);
      if (pick < 70)      span = $urandom_range(1, 6);
      else if (pick < 85) span = $urandom_range(7, 24);
      else if (pick < 95) span = 0;
      else                span = $urandom_range(40, 64);
      if (span == 0) begin
         c.first_addr = 16'($urandom);
         c.limit_addr = 16'($urandom_range(0, c.first_addr));
      end else begin
         case ($urandom_range(0, 7))
            0:       c.first_addr = '0;
            1:       c.first_addr = 16'(32'hFFFF - span);
            default: c.first_addr = 16'($urandom_range(0, 65535 - span));
         endcase
         c.limit_addr = 16'(c.first_addr + span);
      end
      c.first_block = ($urandom_range(0, 3) == 0);
      c.last_block  = ($urandom_range(0, 3) == 0);
      issue_word(c, 1'b0, '0);
      while (mx_phase != mxt_pkg::PH_IDLE) issue_word(make_tick(), 1'b0, '0);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #800000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 80);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_left % 3 != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (march_out_q.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            mon_want = march_out_q.pop_front();
            check_field("access_valid", 32'(mon_want.access_valid), 32'(rsp_access_valid));
            check_field("access_write", 32'(mon_want.access_write), 32'(rsp_access_write));
            check_field("access_addr", 32'(mon_want.access_addr), 32'(rsp_access_addr));
            check_field("write_word", 32'(mon_want.write_word), 32'(rsp_write_word));
            check_field("busy_res", 32'(mon_want.busy), 32'(rsp_busy_res));
            check_field("block_done", 32'(mon_want.block_done), 32'(rsp_block_done));
            check_field("block_result", 32'(mon_want.block_result), 32'(rsp_block_result));
            check_field("overall_result", 32'(mon_want.overall_result),
                        32'(rsp_overall_result));
            check_field("queried_result", 32'(mon_want.queried_result),
                        32'(rsp_queried_result));
            if (rsp_block_done) begin
               blocks_done++;
               if (rsp_block_result == mxt_pkg::RES_NOT_OK) blocks_bad++;
            end
         end
      end
   end

   initial begin
      logic [mxt_pkg::ALG_WIDTH-1:0] alg_plan [4];
      int                            budget   [4];
      int                            target;
      march_cmd_type                 c;

      march_reset();
      alg_plan = '{3'd7, mxt_pkg::ALG_MARCH_X, 3'd1, mxt_pkg::ALG_MARCH_X};
      alg_plan[2] = 3'($urandom_range(1, 6));
      budget   = '{40, 520, 40, 570};

      dir_cmd[0]  = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'hFFFFFFFF, 3'd0);
      dir_cmd[1]  = mk_cmd(mxt_pkg::CMD_START, 16'h0005, 16'h0005, 3'd7, 1'b1, 1'b0,
                           32'h00000000, 3'd7);
      dir_cmd[2]  = mk_cmd(mxt_pkg::CMD_START, 16'hFFFF, 16'h0000, 3'd0, 1'b0, 1'b1,
                           32'hFFFFFFFF, 3'd0);
      dir_cmd[3]  = mk_cmd(mxt_pkg::CMD_START, 16'h0000, 16'h0002, 3'd3, 1'b1, 1'b1,
                           32'h00000000, 3'd3);
      dir_cmd[4]  = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'hA5A5A5A5, 3'd3);
      dir_cmd[5]  = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h5A5A5A5A, 3'd3);
      dir_cmd[6]  = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000000, 3'd3);
      dir_cmd[7]  = mk_cmd(mxt_pkg::CMD_START, 16'hFFFF, 16'hFFFF, 3'd5, 1'b1, 1'b0,
                           32'h00000000, 3'd5);
      dir_cmd[8]  = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000000, 3'd3);
      dir_cmd[9]  = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000000, 3'd3);
      dir_cmd[10] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000001, 3'd3);
      dir_cmd[11] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'hFFFFFFFF, 3'd3);
      dir_cmd[12] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000001, 3'd3);
      dir_cmd[13] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000000, 3'd3);
      dir_cmd[14] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000000, 3'd3);
      dir_cmd[15] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000000, 3'd3);
      dir_cmd[16] = mk_cmd(mxt_pkg::CMD_START, 16'hFFFE, 16'hFFFF, 3'd6, 1'b0, 1'b0,
                           32'h00000000, 3'd6);
      dir_cmd[17] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000000, 3'd6);
      dir_cmd[18] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h80000000, 3'd6);
      dir_cmd[19] = mk_cmd(mxt_pkg::CMD_START, 16'h1234, 16'h1235, 3'd1, 1'b0, 1'b1,
                           32'h00000000, 3'd1);
      dir_cmd[20] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000000, 3'd1);
      dir_cmd[21] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000000, 3'd1);
      dir_cmd[22] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'h00000000, 3'd1);
      dir_cmd[23] = mk_cmd(mxt_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0,
                           32'hFFFFFFFF, 3'd1);

      // idle after reset, empty ranges, first write, clean finish and two failures
      dir_typed[0]  = 1'b1;
      dir_out[0]    = mk_out(1'b0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0, mxt_pkg::RES_NOT_TESTED,
                             mxt_pkg::RES_NOT_TESTED, mxt_pkg::RES_NOT_TESTED);
      dir_typed[1]  = 1'b1;
      dir_out[1]    = mk_out(1'b0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b1, mxt_pkg::RES_OK,
                             mxt_pkg::RES_UNDEF, mxt_pkg::RES_OK);
      dir_typed[2]  = 1'b1;
      dir_out[2]    = mk_out(1'b0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b1, mxt_pkg::RES_OK,
                             mxt_pkg::RES_OK, mxt_pkg::RES_OK);
      dir_typed[3]  = 1'b1;
      dir_out[3]    = mk_out(1'b1, 1'b1, 16'h0, 1'b0, 1'b1, 1'b0, mxt_pkg::RES_NOT_TESTED,
                             mxt_pkg::RES_UNDEF, mxt_pkg::RES_NOT_TESTED);
      dir_typed[15] = 1'b1;
      dir_out[15]   = mk_out(1'b0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b1, mxt_pkg::RES_OK,
                             mxt_pkg::RES_OK, mxt_pkg::RES_OK);
      dir_typed[18] = 1'b1;
      dir_out[18]   = mk_out(1'b0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b1, mxt_pkg::RES_NOT_OK,
                             mxt_pkg::RES_NOT_OK, mxt_pkg::RES_NOT_OK);
      dir_typed[23] = 1'b1;
      dir_out[23]   = mk_out(1'b0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b1, mxt_pkg::RES_NOT_OK,
                             mxt_pkg::RES_NOT_OK, mxt_pkg::RES_NOT_OK);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (3) @(negedge clock);

      for (int i = 0; i < DIR_ROWS; i++) issue_word(dir_cmd[i], dir_typed[i], dir_out[i]);

      for (int p = 0; p < 4; p++) begin
         write_alg(alg_plan[p]);
         target = words_sent + budget[p];
         while (words_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
               c         = make_tick();
               c.command = mxt_pkg::CMD_TICK;
               issue_word(c, 1'b0, '0);
            end else begin
               run_block();
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("sent %0d words; %0d blocks finished, %0d of them not ok", words_sent,
               blocks_done, blocks_bad);
      $display("algorithm settings 0, 7 and %0d, with stalls on both channels", alg_plan[2]);
      if (fail_count == 0 && march_out_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/mxt_pkg.sv
src/mxt_slot_store.sv
src/mxt_engine.sv
src/march_x_ram_test_controller_core.sv
sim/tb.sv
